>>> hw/rtl/vdd_pkg.sv
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared types and constants of the vsync drift detector: register indexes,
// reset values, field widths, controller states and the command and status
// words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vdd_pkg;

    // field widths
    localparam int TS_W     = 63;
    localparam int WORD_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int LIMIT_W  = 40;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;

    // divider step counter width, one quotient bit a step
    localparam int DIV_CNT_W = 6;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY_LIMIT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_LIMIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_COUNT     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_COUNT     = 8'd4;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_REFRESH_PERIOD = 32'd166666;
    localparam logic [LIMIT_W-1:0]  RST_STEADY_LIMIT   = 40'd50000;
    localparam logic [LIMIT_W-1:0]  RST_WARMUP_LIMIT   = 40'd1000000;
    localparam logic [COUNT_W-1:0]  RST_LOSS_COUNT     = 8'd4;
    localparam logic [COUNT_W-1:0]  RST_GAIN_COUNT     = 8'd16;

    localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'hFF;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAG,
        ST_DIV_START,
        ST_DIV,
        ST_ROUND,
        ST_SIGN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMBINE,
        ST_SUM,
        ST_DRIFT,
        ST_DMAG,
        ST_JUDGE
    } vdd_state_t;

    // datapath commands, one step each
    typedef struct packed {
        logic load;
        logic prep;
        logic mag;
        logic div_start;
        logic round;
        logic sign;
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic sum;
        logic drift;
        logic dmag;
        logic judge;
    } vdd_cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } vdd_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/vsync_drift_detector.sv
// words are taken one at a time: a new timestamp only after the last one is judged
// each word runs through the 64-step restoring divider
// a result waits in the output register while the next word is taken in
// reset: synchronous, active low; config registers to their defaults, flag set
// the window memory needs no clearing pass: slots read as zero until it wraps
// ----------------------------------------------------------------------------
// vsync_drift_detector
// Frame-swap timestamp deltas are snapped to whole refresh periods; the
// drift between real and snapped sums over a window drives a vsync flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vsync_drift_detector
    import vdd_pkg::*;
#(
    parameter int WINDOW = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [TS_W-1:0]       s_timestamp,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [WORD_W-1:0]   m_measured_delta,
    output logic signed [WORD_W-1:0]   m_snap_delta,
    output logic signed [WORD_W-1:0]   m_window_drift,
    output logic                       m_vsynced,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    vdd_cmd_t    cmd;
    vdd_status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    vdd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vdd_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_timestamp      (s_timestamp),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_measured_delta (m_measured_delta),
        .m_snap_delta     (m_snap_delta),
        .m_window_drift   (m_window_drift),
        .m_vsynced        (m_vsynced)
    );

endmodule

`default_nettype wire

>>> hw/rtl/vdd_divider.sv
// ----------------------------------------------------------------------------
// vdd_divider
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module vdd_divider
    import vdd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [WORD_W-1:0]   dividend,
    input  wire logic [PERIOD_W-1:0] divisor,
    output logic                     done,
    output logic [WORD_W-1:0]        quotient,
    output logic [PERIOD_W-1:0]      remainder
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(WORD_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0]  div_reg, div_next;

    logic [PERIOD_W:0]    rem_sh;
    logic [PERIOD_W:0]    rem_sub;
    logic                 ge;

    // one shift and trial subtract
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[WORD_W-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};
    end

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[WORD_W-2:0], ge};
            rem_next = ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial results
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/vdd_datapath.sv
// ----------------------------------------------------------------------------
// vdd_datapath
// Registers, arithmetic and window memory of the drift detector; each step
// runs on a command from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module vdd_datapath
    import vdd_pkg::*;
#(
    parameter int WINDOW = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire vdd_cmd_t              cmd,
    output vdd_status_t                status,
    input  wire logic [TS_W-1:0]       s_timestamp,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [WORD_W-1:0]   m_measured_delta,
    output logic signed [WORD_W-1:0]   m_snap_delta,
    output logic signed [WORD_W-1:0]   m_window_drift,
    output logic                       m_vsynced
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
    localparam int HALF_W = WORD_W / 2;

    // configuration registers
    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  steady_reg;
    logic [LIMIT_W-1:0]  warmup_reg;
    logic [COUNT_W-1:0]  loss_reg;
    logic [COUNT_W-1:0]  gain_reg;

    // architectural state
    logic [TS_W-1:0]     last_ts_reg;
    logic [WORD_W-1:0]   snap_err_reg;
    logic [WORD_W-1:0]   ss_reg;
    logic [WORD_W-1:0]   rs_reg;
    logic [IDX_W-1:0]    ring_idx_reg;
    logic                full_reg;
    logic                sync_reg, sync_next;
    logic [COUNT_W-1:0]  hcount_reg, hcount_next;

    // working registers
    logic [WORD_W-1:0]   delta_reg;
    logic [WORD_W-1:0]   num_reg;
    logic [WORD_W-1:0]   half_reg;
    logic                neg_reg;
    logic [WORD_W-1:0]   mag_reg;
    logic [WORD_W-1:0]   q_reg;
    logic [WORD_W-1:0]   est_reg;
    logic [WORD_W-1:0]   prod_lo_reg;
    logic [HALF_W-1:0]   prod_hi_reg;
    logic [WORD_W-1:0]   snapped_reg;
    logic [WORD_W-1:0]   diff_reg;
    logic [WORD_W-1:0]   drift_reg;
    logic [WORD_W-1:0]   dmag_reg;

    // output word
    logic                m_valid_reg;
    logic [WORD_W-1:0]   out_delta_reg;
    logic [WORD_W-1:0]   out_snapped_reg;
    logic [WORD_W-1:0]   out_drift_reg;
    logic                out_sync_reg;

    // window memory, snapped delta in the upper half
    logic [2*WORD_W-1:0] ring_mem [WINDOW];
    logic [2*WORD_W-1:0] ring_q_reg;
    logic [WORD_W-1:0]   old_snapped;
    logic [WORD_W-1:0]   old_real;

    logic                div_done;
    logic [WORD_W-1:0]   div_quo;
    logic [PERIOD_W-1:0] div_rem;

    logic [HALF_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_p;
    logic [WORD_W-1:0]   half_sum;
    logic                round_up;
    logic                hit;
    logic [LIMIT_W-1:0]  limit;
    logic                grow;
    logic [COUNT_W-1:0]  cnt_step;
    logic [COUNT_W-1:0]  thr;

    vdd_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mag_reg),
        .divisor   (period_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= RST_REFRESH_PERIOD;
            steady_reg <= RST_STEADY_LIMIT;
            warmup_reg <= RST_WARMUP_LIMIT;
            loss_reg   <= RST_LOSS_COUNT;
            gain_reg   <= RST_GAIN_COUNT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REFRESH_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_STEADY_LIMIT:   steady_reg <= cfg_data[LIMIT_W-1:0];
                CFG_WARMUP_LIMIT:   warmup_reg <= cfg_data[LIMIT_W-1:0];
                CFG_LOSS_COUNT:     loss_reg   <= cfg_data[COUNT_W-1:0];
                CFG_GAIN_COUNT:     gain_reg   <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // window memory, read every cycle at the current slot
    always_ff @(posedge aclk) begin
        if (cmd.drift) begin
            ring_mem[ring_idx_reg] <= {snapped_reg, delta_reg};
        end
        ring_q_reg <= ring_mem[ring_idx_reg];
    end

    // slots not yet written read as zero until the window has wrapped
    always_comb begin
        old_snapped = full_reg ? ring_q_reg[2*WORD_W-1:WORD_W] : '0;
        old_real    = full_reg ? ring_q_reg[WORD_W-1:0] : '0;
    end

    // halve toward zero: add one to a negative value, then shift arithmetically
    always_comb begin
        half_sum = snap_err_reg + {{(WORD_W-1){1'b0}}, snap_err_reg[WORD_W-1]};
    end

    // half away from zero on the remainder
    always_comb begin
        round_up = {div_rem, 1'b0} >= {1'b0, period_reg};
    end

    // shared 32 by 32 multiplier over the two halves of the quotient
    always_comb begin
        mul_a = cmd.mul_hi ? est_reg[WORD_W-1:HALF_W] : est_reg[HALF_W-1:0];
        mul_p = mul_a * period_reg;
    end

    // drift test and hysteresis
    always_comb begin
        limit       = full_reg ? steady_reg : warmup_reg;
        hit         = dmag_reg < {{(WORD_W-LIMIT_W){1'b0}}, limit};
        grow        = sync_reg ? !hit : hit;
        thr         = sync_reg ? loss_reg : gain_reg;
        if (grow) begin
            cnt_step = (hcount_reg == COUNT_MAX) ? hcount_reg : hcount_reg + 1'b1;
        end else begin
            cnt_step = (hcount_reg == '0) ? hcount_reg : hcount_reg - 1'b1;
        end
        sync_next   = sync_reg;
        hcount_next = cnt_step;
        if (cnt_step >= thr) begin
            sync_next   = !sync_reg;
            hcount_next = '0;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ts_reg  <= '0;
            snap_err_reg <= '0;
            ss_reg       <= '0;
            rs_reg       <= '0;
            ring_idx_reg <= '0;
            full_reg     <= 1'b0;
            sync_reg     <= 1'b1;
            hcount_reg   <= '0;
        end else begin
            if (cmd.load) begin
                last_ts_reg <= s_timestamp;
            end
            if (cmd.sum) begin
                ss_reg <= ss_reg - old_snapped + snapped_reg;
                rs_reg <= rs_reg - old_real + delta_reg;
            end
            if (cmd.drift) begin
                snap_err_reg <= half_reg + diff_reg;
                if (ring_idx_reg == LAST_IDX) begin
                    ring_idx_reg <= '0;
                    full_reg     <= 1'b1;
                end else begin
                    ring_idx_reg <= ring_idx_reg + 1'b1;
                end
            end
            if (cmd.judge) begin
                sync_reg   <= sync_next;
                hcount_reg <= hcount_next;
            end
        end
    end

    // working registers, one step per command
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            delta_reg <= {1'b0, s_timestamp} - {1'b0, last_ts_reg};
        end
        if (cmd.prep) begin
            num_reg  <= delta_reg + snap_err_reg;
            half_reg <= {half_sum[WORD_W-1], half_sum[WORD_W-1:1]};
        end
        if (cmd.mag) begin
            neg_reg <= num_reg[WORD_W-1];
            mag_reg <= num_reg[WORD_W-1] ? (~num_reg + 1'b1) : num_reg;
        end
        if (cmd.round) begin
            q_reg <= div_quo + {{(WORD_W-1){1'b0}}, round_up};
        end
        if (cmd.sign) begin
            if (period_reg == '0) begin
                est_reg <= '0;
            end else begin
                est_reg <= neg_reg ? (~q_reg + 1'b1) : q_reg;
            end
        end
        if (cmd.mul_lo) begin
            prod_lo_reg <= mul_p;
        end
        if (cmd.mul_hi) begin
            prod_hi_reg <= mul_p[HALF_W-1:0];
        end
        if (cmd.combine) begin
            snapped_reg <= prod_lo_reg + {prod_hi_reg, {HALF_W{1'b0}}};
        end
        if (cmd.sum) begin
            diff_reg <= delta_reg - snapped_reg;
        end
        if (cmd.drift) begin
            drift_reg <= rs_reg - ss_reg;
        end
        if (cmd.dmag) begin
            dmag_reg <= drift_reg[WORD_W-1] ? (~drift_reg + 1'b1) : drift_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.judge) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.judge) begin
            out_delta_reg   <= delta_reg;
            out_snapped_reg <= snapped_reg;
            out_drift_reg   <= drift_reg;
            out_sync_reg    <= sync_next;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_measured_delta = $signed(out_delta_reg);
    assign m_snap_delta     = $signed(out_snapped_reg);
    assign m_window_drift   = $signed(out_drift_reg);
    assign m_vsynced        = out_sync_reg;

endmodule

`default_nettype wire

>>> hw/rtl/vdd_ctrl.sv
// ----------------------------------------------------------------------------
// vdd_ctrl
// Sequencer of the drift detector: steps one word through the datapath,
// waits on the divider and on a free output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdd_ctrl
    import vdd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire vdd_status_t status,
    output vdd_cmd_t         cmd
);

    vdd_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_PREP;
            ST_PREP:      state_next = ST_MAG;
            ST_MAG:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:       if (status.div_done) state_next = ST_ROUND;
            ST_ROUND:     state_next = ST_SIGN;
            ST_SIGN:      state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_COMBINE;
            ST_COMBINE:   state_next = ST_SUM;
            ST_SUM:       state_next = ST_DRIFT;
            ST_DRIFT:     state_next = ST_DMAG;
            ST_DMAG:      state_next = ST_JUDGE;
            ST_JUDGE:     if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP:      cmd.prep      = 1'b1;
            ST_MAG:       cmd.mag       = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV:       cmd.round     = 1'b0;
            ST_ROUND:     cmd.round     = 1'b1;
            ST_SIGN:      cmd.sign      = 1'b1;
            ST_MUL_LO:    cmd.mul_lo    = 1'b1;
            ST_MUL_HI:    cmd.mul_hi    = 1'b1;
            ST_COMBINE:   cmd.combine   = 1'b1;
            ST_SUM:       cmd.sum       = 1'b1;
            ST_DRIFT:     cmd.drift     = 1'b1;
            ST_DMAG:      cmd.dmag      = 1'b1;
            ST_JUDGE:     cmd.judge     = status.out_free;
            default:      cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/vdd_checker.sv
// ----------------------------------------------------------------------------
// vdd_checker
// Port-level checks of the drift detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vdd_checker
    import vdd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic signed [WORD_W-1:0] m_measured_delta,
    input wire logic signed [WORD_W-1:0] m_snap_delta,
    input wire logic signed [WORD_W-1:0] m_window_drift,
    input wire logic                  m_vsynced
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_measured_delta)
            && $stable(m_snap_delta) && $stable(m_window_drift)
            && $stable(m_vsynced))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an accept");

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind vsync_drift_detector vdd_checker u_vdd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_measured_delta (m_measured_delta),
    .m_snap_delta     (m_snap_delta),
    .m_window_drift   (m_window_drift),
    .m_vsynced        (m_vsynced)
);

`default_nettype wire
